// ===== rtl/bpr_pkg.sv =====
// Shared types, constants and helper functions of the bit-parallel regex matcher.
package bpr_pkg;

  localparam int STATE_BITS    = 64;
  localparam int MAX_LEVELS    = 8;
  localparam int ALPHABET_SIZE = 256;

  localparam int SB        = STATE_BITS;
  localparam int LVL_W     = $clog2(MAX_LEVELS + 1);
  localparam int LVL_ROWS  = MAX_LEVELS + 1;
  localparam int LVL_DEPTH = 3 * LVL_ROWS;
  localparam int LVL_AW    = $clog2(LVL_DEPTH);
  localparam int CH_AW     = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  localparam int ROW_SCT = 0;
  localparam int ROW_GTH = LVL_ROWS;
  localparam int ROW_PRP = 2 * LVL_ROWS;

  localparam logic [1:0] FN_START = 2'd0;
  localparam logic [1:0] FN_CHAR  = 2'd1;
  localparam logic [1:0] FN_LOAD  = 2'd2;

  localparam logic [2:0] TBL_ADV = 3'd0;
  localparam logic [2:0] TBL_REP = 3'd1;
  localparam logic [2:0] TBL_SCT = 3'd2;
  localparam logic [2:0] TBL_GTH = 3'd3;
  localparam logic [2:0] TBL_PRP = 3'd4;

  localparam logic [1:0] PART_BLK = 2'd0;
  localparam logic [1:0] PART_SRC = 2'd1;
  localparam logic [1:0] PART_DST = 2'd2;

  localparam logic [1:0] CFG_LEVELS = 2'd0;
  localparam logic [1:0] CFG_ACTIVE = 2'd1;
  localparam logic [1:0] CFG_ACCEPT = 2'd2;

  typedef enum logic [1:0] {
    OP_SCT,
    OP_GTH,
    OP_PRP
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_CLOSE,
    ST_FINISH
  } seq_st_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_value;
    logic [2:0]  table_id;
    logic [3:0]  level_index;
    logic [1:0]  mask_part;
    logic [63:0] mask_word;
  } item_t;

  typedef struct packed {
    logic              init;
    logic              init_char;
    logic              rd_en;
    logic [LVL_AW-1:0] rd_row;
    logic              op_v;
    op_kind_t          op_kind;
    logic              op_last;
  } seq_ctl_t;

  typedef struct packed {
    logic in_ready;
    logic out_load;
  } seq_sts_t;

  function automatic logic [LVL_AW-1:0] lvl_row(op_kind_t kind, logic [LVL_W-1:0] lvl);
    logic [LVL_AW-1:0] base;
    unique case (kind)
      OP_SCT:  base = LVL_AW'(ROW_SCT);
      OP_GTH:  base = LVL_AW'(ROW_GTH);
      OP_PRP:  base = LVL_AW'(ROW_PRP);
      default: base = LVL_AW'(ROW_SCT);
    endcase
    return base + LVL_AW'(lvl);
  endfunction

  // Bit 0 is always live, so a count of zero behaves as one.
  function automatic logic [SB-1:0] live_mask(logic [6:0] n);
    logic [SB-1:0] m;
    for (int i = 0; i < SB; i++) begin
      m[i] = (i == 0) || (7'(i) < n);
    end
    return m;
  endfunction

endpackage

// ===== rtl/bpr_seq.sv =====
// Sequencer that walks the closure levels and issues mask memory reads.
module bpr_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_acc,
  input  logic [1:0]                in_func,
  input  logic [bpr_pkg::LVL_W-1:0] depth,
  input  logic                      out_free,
  output bpr_pkg::seq_ctl_t         ctl,
  output bpr_pkg::seq_sts_t         sts
);

  bpr_pkg::seq_st_t  st_r, st_nxt;
  bpr_pkg::op_kind_t kind_r, kind_nxt;
  logic [bpr_pkg::LVL_W-1:0] lvl_r, lvl_nxt;
  logic              up_r, up_nxt;
  logic              iss_done_r;
  logic              char_r;
  logic              op_v_r;
  bpr_pkg::op_kind_t op_kind_r;
  logic              op_last_r;
  logic              cur_last;
  logic              rd_en;

  always_comb begin
    kind_nxt = kind_r;
    lvl_nxt  = lvl_r;
    up_nxt   = up_r;
    cur_last = 1'b0;
    unique case (kind_r)
      bpr_pkg::OP_GTH: begin
        kind_nxt = bpr_pkg::OP_PRP;
      end
      bpr_pkg::OP_SCT: begin
        kind_nxt = bpr_pkg::OP_PRP;
        lvl_nxt  = lvl_r + 1'b1;
      end
      bpr_pkg::OP_PRP: begin
        if (!up_r) begin
          if (lvl_r != '0) begin
            kind_nxt = bpr_pkg::OP_GTH;
            lvl_nxt  = lvl_r - 1'b1;
          end else if (depth == '0) begin
            cur_last = 1'b1;
          end else begin
            kind_nxt = bpr_pkg::OP_SCT;
            up_nxt   = 1'b1;
          end
        end else if (lvl_r == depth) begin
          cur_last = 1'b1;
        end else begin
          kind_nxt = bpr_pkg::OP_SCT;
        end
      end
      default: begin
        cur_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bpr_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_func == bpr_pkg::FN_START || in_func == bpr_pkg::FN_CHAR) begin
            st_nxt = bpr_pkg::ST_PREP;
          end else begin
            st_nxt = bpr_pkg::ST_FINISH;
          end
        end
      end
      bpr_pkg::ST_PREP: begin
        st_nxt = bpr_pkg::ST_CLOSE;
      end
      bpr_pkg::ST_CLOSE: begin
        if (op_v_r && op_last_r) begin
          st_nxt = bpr_pkg::ST_FINISH;
        end
      end
      bpr_pkg::ST_FINISH: begin
        if (out_free) begin
          st_nxt = bpr_pkg::ST_IDLE;
        end
      end
      default: st_nxt = bpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en = (st_r == bpr_pkg::ST_PREP) || (st_r == bpr_pkg::ST_CLOSE && !iss_done_r);
    ctl.init      = (st_r == bpr_pkg::ST_PREP);
    ctl.init_char = char_r;
    ctl.rd_en     = rd_en;
    ctl.rd_row    = bpr_pkg::lvl_row(kind_r, lvl_r);
    ctl.op_v      = op_v_r;
    ctl.op_kind   = op_kind_r;
    ctl.op_last   = op_last_r;
    sts.in_ready  = (st_r == bpr_pkg::ST_IDLE);
    sts.out_load  = (st_r == bpr_pkg::ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= bpr_pkg::ST_IDLE;
      op_v_r     <= 1'b0;
      iss_done_r <= 1'b0;
      char_r     <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      op_v_r <= rd_en;
      if (in_acc) begin
        iss_done_r <= 1'b0;
        char_r     <= (in_func == bpr_pkg::FN_CHAR);
      end else if (rd_en) begin
        iss_done_r <= cur_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= bpr_pkg::OP_PRP;
      lvl_r  <= depth;
      up_r   <= 1'b0;
    end else if (rd_en) begin
      kind_r <= kind_nxt;
      lvl_r  <= lvl_nxt;
      up_r   <= up_nxt;
    end
    if (rd_en) begin
      op_kind_r <= kind_r;
      op_last_r <= cur_last;
    end
  end

endmodule

// ===== rtl/bpr_core.sv =====
// Mask memories, NFA state register and the closure arithmetic.
module bpr_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_acc,
  input  bpr_pkg::item_t         item,
  input  bpr_pkg::seq_ctl_t      ctl,
  input  logic [bpr_pkg::SB-1:0] live,
  input  logic [5:0]             accept_pos,
  output logic [bpr_pkg::SB-1:0] nfa,
  output logic                   matched
);

  logic [bpr_pkg::SB-1:0] adv_mem [bpr_pkg::ALPHABET_SIZE];
  logic [bpr_pkg::SB-1:0] rep_mem [bpr_pkg::ALPHABET_SIZE];
  logic [bpr_pkg::SB-1:0] blk_mem [bpr_pkg::LVL_DEPTH];
  logic [bpr_pkg::SB-1:0] src_mem [bpr_pkg::LVL_DEPTH];
  logic [bpr_pkg::SB-1:0] dst_mem [bpr_pkg::LVL_DEPTH];

  logic [bpr_pkg::SB-1:0] adv_q, rep_q, blk_q, src_q, dst_q;
  logic                   ch_ok_r;
  logic [bpr_pkg::SB-1:0] nfa_r, nfa_nxt;
  logic                   match_r, match_nxt;

  logic                    ch_ok, part_ok, lvl_ok, lvl_wr, load_en, char_rd;
  logic [bpr_pkg::CH_AW-1:0]  ch_idx;
  logic [bpr_pkg::LVL_AW-1:0] wr_row;
  bpr_pkg::op_kind_t       ld_kind;
  logic [bpr_pkg::SB-1:0]  word, adv_v, rep_v, a_prp, op_res, step;
  logic [63:0]             res_ext;

  always_comb begin
    ch_ok   = {1'b0, item.char_value} < 9'(bpr_pkg::ALPHABET_SIZE);
    ch_idx  = item.char_value[bpr_pkg::CH_AW-1:0];
    load_en = in_acc && (item.func == bpr_pkg::FN_LOAD);
    char_rd = in_acc && (item.func == bpr_pkg::FN_CHAR);
    part_ok = (item.mask_part == bpr_pkg::PART_BLK) || (item.mask_part == bpr_pkg::PART_SRC)
           || (item.mask_part == bpr_pkg::PART_DST);
    word    = item.mask_word[bpr_pkg::SB-1:0];
    ld_kind = bpr_pkg::OP_SCT;
    lvl_ok  = 1'b0;
    unique case (item.table_id)
      bpr_pkg::TBL_SCT: begin
        ld_kind = bpr_pkg::OP_SCT;
        lvl_ok  = {1'b0, item.level_index} < 5'(bpr_pkg::MAX_LEVELS);
      end
      bpr_pkg::TBL_GTH: begin
        ld_kind = bpr_pkg::OP_GTH;
        lvl_ok  = {1'b0, item.level_index} < 5'(bpr_pkg::MAX_LEVELS);
      end
      bpr_pkg::TBL_PRP: begin
        ld_kind = bpr_pkg::OP_PRP;
        lvl_ok  = {1'b0, item.level_index} <= 5'(bpr_pkg::MAX_LEVELS);
      end
      default: lvl_ok = 1'b0;
    endcase
    lvl_wr = load_en && part_ok && lvl_ok;
    wr_row = bpr_pkg::lvl_row(ld_kind, bpr_pkg::LVL_W'(item.level_index));
  end

  always_ff @(posedge clk) begin
    if (load_en && ch_ok && item.table_id == bpr_pkg::TBL_ADV) begin
      adv_mem[ch_idx] <= word;
    end
    if (load_en && ch_ok && item.table_id == bpr_pkg::TBL_REP) begin
      rep_mem[ch_idx] <= word;
    end
    if (char_rd) begin
      adv_q   <= adv_mem[ch_idx];
      rep_q   <= rep_mem[ch_idx];
      ch_ok_r <= ch_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_wr && item.mask_part == bpr_pkg::PART_BLK) begin
      blk_mem[wr_row] <= word;
    end
    if (lvl_wr && item.mask_part == bpr_pkg::PART_SRC) begin
      src_mem[wr_row] <= word;
    end
    if (lvl_wr && item.mask_part == bpr_pkg::PART_DST) begin
      dst_mem[wr_row] <= word;
    end
    if (ctl.rd_en) begin
      blk_q <= blk_mem[ctl.rd_row];
      src_q <= src_mem[ctl.rd_row];
      dst_q <= dst_mem[ctl.rd_row];
    end
  end

  always_comb begin
    adv_v = ch_ok_r ? adv_q : '0;
    rep_v = ch_ok_r ? rep_q : '0;
    step  = (((nfa_r << 1) & adv_v) | bpr_pkg::SB'(1) | (nfa_r & rep_v)) & live;
    a_prp = (dst_q | (nfa_r & blk_q)) & live;
    unique case (ctl.op_kind)
      bpr_pkg::OP_SCT: op_res = nfa_r | ((blk_q - (nfa_r & src_q)) & dst_q & live);
      bpr_pkg::OP_GTH: op_res = nfa_r | ((blk_q + (nfa_r & src_q)) & dst_q & live);
      bpr_pkg::OP_PRP: op_res = nfa_r | (blk_q & ((~(a_prp - src_q)) ^ a_prp) & live);
      default:         op_res = nfa_r;
    endcase
    res_ext   = 64'(op_res);
    nfa_nxt   = nfa_r;
    match_nxt = match_r;
    if (ctl.init) begin
      nfa_nxt = ctl.init_char ? step : bpr_pkg::SB'(1);
      if (!ctl.init_char) begin
        match_nxt = 1'b0;
      end
    end else if (ctl.op_v) begin
      nfa_nxt = op_res;
      if (ctl.op_last) begin
        match_nxt = match_r | res_ext[accept_pos];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nfa_r   <= '0;
      match_r <= 1'b0;
    end else begin
      nfa_r   <= nfa_nxt;
      match_r <= match_nxt;
    end
  end

  assign nfa     = nfa_r;
  assign matched = match_r;

endmodule

// ===== rtl/bit_parallel_regex_nfa_matcher.sv =====
// Top level of the bit-parallel Thompson NFA regex matcher.
// Start and text words pass through a preparation state and a closure walk over the levels to the result.
// Each closure step reads one level mask row and applies one mask operation per cycle.
// Load words and unused function codes go straight from acceptance to the result; one word is handled at a time.
// Synchronous active-low reset clears the NFA state, the match flag and the output valid flag.
// Mask memories are not cleared by reset and hold nothing meaningful until written.
module bit_parallel_regex_nfa_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // char_value, level_index, mask_word, zero fill
  input  logic [6:0]  in_tuser,   // func, table_id, mask_part
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // matched, state_vector, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [6:0]  cfg_data
);

  logic [3:0] level_count_r;
  logic [6:0] active_bits_r;
  logic [5:0] accept_pos_r;
  logic       out_valid_r;
  logic [71:0] out_data_r;

  bpr_pkg::item_t    item;
  bpr_pkg::seq_ctl_t ctl;
  bpr_pkg::seq_sts_t sts;
  logic              in_acc, out_free;
  logic [bpr_pkg::LVL_W-1:0] depth;
  logic [bpr_pkg::SB-1:0]    live, nfa;
  logic              matched;

  always_comb begin
    item.func        = in_tuser[1:0];
    item.table_id    = in_tuser[4:2];
    item.mask_part   = in_tuser[6:5];
    item.char_value  = in_tdata[7:0];
    item.level_index = in_tdata[11:8];
    item.mask_word   = in_tdata[75:12];
    in_acc    = in_tvalid && sts.in_ready;
    out_free  = !out_valid_r || out_tready;
    depth     = ({1'b0, level_count_r} > 5'(bpr_pkg::MAX_LEVELS))
              ? bpr_pkg::LVL_W'(bpr_pkg::MAX_LEVELS) : bpr_pkg::LVL_W'(level_count_r);
    live      = bpr_pkg::live_mask(active_bits_r);
  end

  assign in_tready  = sts.in_ready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= 4'd0;
      active_bits_r <= 7'd64;
      accept_pos_r  <= 6'd0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        bpr_pkg::CFG_LEVELS: level_count_r <= cfg_data[3:0];
        bpr_pkg::CFG_ACTIVE: active_bits_r <= cfg_data;
        bpr_pkg::CFG_ACCEPT: accept_pos_r  <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sts.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.out_load) begin
      out_data_r <= {7'd0, 64'(nfa), matched};
    end
  end

  bpr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_func  (item.func),
    .depth    (depth),
    .out_free (out_free),
    .ctl      (ctl),
    .sts      (sts)
  );

  bpr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .item       (item),
    .ctl        (ctl),
    .live       (live),
    .accept_pos (accept_pos_r),
    .nfa        (nfa),
    .matched    (matched)
  );

endmodule

// ===== rtl/bpr_checker.sv =====
// Port-level assertions for the regex matcher and the bind that attaches them.
module bpr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // A stalled result word stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed or dropped while stalled");

  // Only one word is in work at a time, so the input closes straight after acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again before the previous word finished");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid directly after reset");

endmodule

bind bit_parallel_regex_nfa_matcher bpr_checker u_bpr_checker (.*);
